### rtl/i2crts_pkg.sv
`timescale 1ns / 1ps

package i2crts_pkg;

   localparam int COUNT_BITS = 16;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_START = 4'd1;
   localparam logic [3:0] PH_SLAW  = 4'd2;
   localparam logic [3:0] PH_REG   = 4'd3;
   localparam logic [3:0] PH_DATA  = 4'd4;
   localparam logic [3:0] PH_REP   = 4'd5;
   localparam logic [3:0] PH_SLAR  = 4'd6;
   localparam logic [3:0] PH_ACK   = 4'd7;
   localparam logic [3:0] PH_NACK  = 4'd8;

   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_REP_START = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;
   localparam logic [7:0] STATUS_MASK  = 8'b11111000;

   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_START     = 3'd1;
   localparam logic [2:0] ACT_SEND      = 3'd2;
   localparam logic [2:0] ACT_READ_ACK  = 3'd3;
   localparam logic [2:0] ACT_READ_NACK = 3'd4;
   localparam logic [2:0] ACT_STOP      = 3'd5;

   typedef struct packed {
      logic [3:0]            phase;
      logic                  is_read;
      logic [6:0]            target_address;
      logic [7:0]            register_index;
      logic [7:0]            pending_write_byte;
      logic [COUNT_BITS-1:0] bytes_left;
   } seq_state_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] action_byte;
      logic [7:0] read_data;
      logic       read_valid;
      logic       last_byte;
      logic       done_res;
      logic       success;
   } seq_result_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  device_address;
      logic [7:0]  register_address;
      logic [7:0]  write_data;
      logic [15:0] byte_count;
      logic [7:0]  bus_status;
      logic [7:0]  bus_data;
   } seq_item_type;

   function automatic logic [7:0] expected_status(input logic [3:0] ph);
      logic [7:0] st;
      case (ph)
         PH_START: st = ST_START;
         PH_SLAW:  st = ST_SLA_W_ACK;
         PH_REG:   st = ST_DATA_ACK;
         PH_DATA:  st = ST_DATA_ACK;
         PH_REP:   st = ST_REP_START;
         PH_SLAR:  st = ST_SLA_R_ACK;
         PH_ACK:   st = ST_RX_ACK;
         default:  st = ST_RX_NACK;
      endcase
      return st;
   endfunction

endpackage

### rtl/i2crts_step.sv
`timescale 1ns / 1ps

module i2crts_step (
   input  i2crts_pkg::seq_item_type   item,
   input  i2crts_pkg::seq_state_type  cur,
   output i2crts_pkg::seq_state_type  nxt,
   output i2crts_pkg::seq_result_type res
);
   import i2crts_pkg::*;

   logic [7:0]            status_masked;
   logic [COUNT_BITS-1:0] rd_cnt;

   assign status_masked = item.bus_status & STATUS_MASK;
   assign rd_cnt = (cur.phase == PH_ACK) ? cur.bytes_left - COUNT_BITS'(1) : cur.bytes_left;

   always_comb begin
      nxt = cur;
      res = '0;
      if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
         if (cur.phase == PH_IDLE) begin
            nxt.is_read            = (item.opcode == OP_READ);
            nxt.target_address     = item.device_address;
            nxt.register_index     = item.register_address;
            nxt.pending_write_byte = item.write_data;
            nxt.bytes_left         = item.byte_count[COUNT_BITS-1:0];
            nxt.phase              = PH_START;
            res.action             = ACT_START;
         end
      end else if (item.opcode == OP_EVENT && cur.phase != PH_IDLE) begin
         if (cur.phase > PH_NACK || status_masked != expected_status(cur.phase)) begin
            nxt.phase    = PH_IDLE;
            res.done_res = 1'b1;
         end else begin
            unique case (cur.phase)
               PH_START: begin
                  res.action      = ACT_SEND;
                  res.action_byte = {cur.target_address, 1'b0};
                  nxt.phase       = PH_SLAW;
               end
               PH_SLAW: begin
                  res.action      = ACT_SEND;
                  res.action_byte = cur.register_index;
                  nxt.phase       = PH_REG;
               end
               PH_REG: begin
                  if (cur.is_read) begin
                     res.action = ACT_START;
                     nxt.phase  = PH_REP;
                  end else begin
                     res.action      = ACT_SEND;
                     res.action_byte = cur.pending_write_byte;
                     nxt.phase       = PH_DATA;
                  end
               end
               PH_DATA: begin
                  res.action   = ACT_STOP;
                  nxt.phase    = PH_IDLE;
                  res.done_res = 1'b1;
                  res.success  = 1'b1;
               end
               PH_REP: begin
                  res.action      = ACT_SEND;
                  res.action_byte = {cur.target_address, 1'b1};
                  nxt.phase       = PH_SLAR;
               end
               PH_SLAR, PH_ACK: begin
                  if (cur.phase == PH_ACK) begin
                     res.read_data  = item.bus_data;
                     res.read_valid = 1'b1;
                     nxt.bytes_left = rd_cnt;
                  end
                  if (rd_cnt == '0) begin
                     res.action = ACT_STOP;
                     nxt.phase  = PH_IDLE;
                     if (cur.phase == PH_SLAR) begin
                        res.done_res = 1'b1;
                        res.success  = 1'b1;
                     end
                  end else if (rd_cnt == COUNT_BITS'(1)) begin
                     res.action = ACT_READ_NACK;
                     nxt.phase  = PH_NACK;
                  end else begin
                     res.action = ACT_READ_ACK;
                     nxt.phase  = PH_ACK;
                  end
               end
               default: begin
                  res.read_data  = item.bus_data;
                  res.read_valid = 1'b1;
                  res.last_byte  = 1'b1;
                  nxt.bytes_left = '0;
                  res.action     = ACT_STOP;
                  nxt.phase      = PH_IDLE;
                  res.done_res   = 1'b1;
                  res.success    = 1'b1;
               end
            endcase
         end
      end
   end

endmodule

### rtl/i2c_register_transaction_sequencer_unit.sv
`timescale 1ns / 1ps
// I2C register transaction sequencer.
// req channel: one item is a command (register write or register read of
// byte_count bytes) or a bus status event from the I2C engine. Every
// accepted item yields exactly one rsp item: the next bus action to issue,
// a received register byte with its last flag, and done/success when the
// transaction ends. Commands while busy and events while idle give an
// all-zero rsp item.
// The rsp item is registered and is valid in the cycle after acceptance.
// Throughput: one item per cycle unless rsp stalls; transaction state
// and rsp register update in the same cycle from a single decode step.
// rsp stall: req_ready follows the rsp register; a new item is taken in
// the same cycle the held rsp item is taken, otherwise req waits.
// Reset (synchronous): sequencer returns to idle, counters and captured
// addresses clear, rsp_valid drops.
module i2c_register_transaction_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_device_address,
   input  logic [7:0]  req_register_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_byte_count,
   input  logic [7:0]  req_bus_status,
   input  logic [7:0]  req_bus_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [7:0]  rsp_action_byte,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic        rsp_last_byte,
   output logic        rsp_done_res,
   output logic        rsp_success
);
   import i2crts_pkg::*;

   seq_item_type   item;
   seq_state_type  state_ff;
   seq_state_type  state_in;
   seq_result_type res;
   seq_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           accept;

   assign item.opcode           = req_opcode;
   assign item.device_address   = req_device_address;
   assign item.register_address = req_register_address;
   assign item.write_data       = req_write_data;
   assign item.byte_count       = req_byte_count;
   assign item.bus_status       = req_bus_status;
   assign item.bus_data         = req_bus_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   i2crts_step u_step (
      .item (item),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_ff.action;
   assign rsp_action_byte = rsp_ff.action_byte;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_read_valid  = rsp_ff.read_valid;
   assign rsp_last_byte   = rsp_ff.last_byte;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_success     = rsp_ff.success;

endmodule
